// File: hdl/sabtb_pkg.sv
// ============================================================================
// sabtb_pkg
// Shared constants, types and helper functions of the set-associative branch
// target buffer with LRU replacement.
// ============================================================================
package sabtb_pkg;

    // Geometry of the buffer
    localparam int ENTRY_COUNT = 1024;
    localparam int WAY_COUNT   = 4;
    localparam int SET_COUNT   = ((ENTRY_COUNT / WAY_COUNT) > 0) ?
                                 (ENTRY_COUNT / WAY_COUNT) : 1;
    localparam bit SET_POW2    = ((SET_COUNT & (SET_COUNT - 1)) == 0);
    localparam int IDX_W       = (SET_COUNT > 1) ? $clog2(SET_COUNT) : 1;
    localparam int REM_W       = IDX_W + 1;
    localparam int WAY_W       = (WAY_COUNT > 1) ? $clog2(WAY_COUNT) : 1;

    // Field widths
    localparam int ADDR_W   = 48;
    localparam int SIZE_W   = 4;
    localparam int STAMP_W  = 32;
    localparam int PEN_W    = 8;
    localparam int STALL_W  = 9;
    localparam int OWAY_W   = 2;

    // Set index reduction for set counts that are not a power of two
    localparam int MOD_BITS  = 4;
    localparam int MOD_STEPS = (ADDR_W + MOD_BITS - 1) / MOD_BITS;
    localparam int MCNT_W    = (MOD_STEPS > 1) ? $clog2(MOD_STEPS) : 1;

    // Configuration port
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam logic REG_MISS_PEN = 1'b0;
    localparam logic REG_MISP_PEN = 1'b1;

    // One way of a set as held in the memory
    typedef struct packed {
        logic               valid;
        logic               cond;
        logic [ADDR_W-1:0]  tag;
        logic [ADDR_W-1:0]  target;
        logic [STAMP_W-1:0] stamp;
    } t_way;

    typedef t_way [WAY_COUNT-1:0] t_row;
    typedef logic [REM_W-1:0]     t_rem;

    // One step of the running remainder: shift in MOD_BITS address bits,
    // each followed by a conditional subtraction of the set count.
    function automatic t_rem mod_step(input t_rem rem_in,
                                      input logic [MOD_BITS-1:0] bits_in);
        t_rem rem;
        rem = rem_in;
        for (int k = MOD_BITS - 1; k >= 0; k--) begin
            rem = {rem[REM_W-2:0], bits_in[k]};
            if (rem >= REM_W'(SET_COUNT)) begin
                rem = rem - REM_W'(SET_COUNT);
            end
        end
        return rem;
    endfunction

endpackage

// File: hdl/sabtb_br_if.sv
// ============================================================================
// sabtb_br_if
// Channel carrying one resolved branch into the buffer.
// ============================================================================
interface sabtb_br_if;
    import sabtb_pkg::*;

    logic                valid;
    logic                ready;
    logic [ADDR_W-1:0]   branch_addr;
    logic [SIZE_W-1:0]   instr_size;
    logic                is_conditional;
    logic [ADDR_W-1:0]   next_addr;
    logic                predicted_taken;
    logic [STAMP_W-1:0]  cycle_now;

    modport source (
        output valid, branch_addr, instr_size, is_conditional, next_addr,
               predicted_taken, cycle_now,
        input  ready
    );

    modport sink (
        input  valid, branch_addr, instr_size, is_conditional, next_addr,
               predicted_taken, cycle_now,
        output ready
    );
endinterface

// File: hdl/sabtb_res_if.sv
// ============================================================================
// sabtb_res_if
// Channel carrying one lookup result out of the buffer.
// ============================================================================
interface sabtb_res_if;
    import sabtb_pkg::*;

    logic                valid;
    logic                ready;
    logic                btb_hit;
    logic [OWAY_W-1:0]   hit_way;
    logic                resolved_taken;
    logic                mispredicted;
    logic [STALL_W-1:0]  stall_cycles;

    modport source (
        output valid, btb_hit, hit_way, resolved_taken, mispredicted, stall_cycles,
        input  ready
    );

    modport sink (
        input  valid, btb_hit, hit_way, resolved_taken, mispredicted, stall_cycles,
        output ready
    );
endinterface

// File: hdl/set_assoc_btb_lru.sv
// ============================================================================
// set_assoc_btb_lru
// Set-associative branch target buffer with LRU replacement. One set row is
// read from a synchronous memory, looked up, updated and written back.
// ============================================================================
//
//  Channel    Direction  Handshake           Contents
//  i_br       in         valid/ready         one resolved branch
//  o_res      out        valid/ready         hit, way, direction, stall cycles
//  APB        in/out     psel/penable/pready miss and mispredict penalties
//
//  When the set count is a power of two an item passes accept and row read,
//  lookup and victim choice, then write-back and result register. Other set
//  counts add the set index reduction steps and a row read before the lookup.
//  The sequencer bounds the rate to one item at a time.
//  After reset a clearing pass over all SET_COUNT sets (256 by default) zeroes the
//  valid bits; no branch is accepted meanwhile, register writes are.
//  A result waiting in the output register stalls only the write-back step.
//
module set_assoc_btb_lru (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    sabtb_br_if.sink                        i_br,
    sabtb_res_if.source                     o_res,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [sabtb_pkg::PADDR_W-1:0]   paddr,
    input  logic [sabtb_pkg::PDATA_W-1:0]   pwdata,
    output logic [sabtb_pkg::PDATA_W-1:0]   prdata,
    output logic                            pready
);
    import sabtb_pkg::*;

    // State codes
    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_MOD   = 3'd2;
    localparam logic [2:0] ST_READ  = 3'd3;
    localparam logic [2:0] ST_LOOK  = 3'd4;
    localparam logic [2:0] ST_WRITE = 3'd5;

    logic [2:0]          r_state;
    logic [IDX_W-1:0]    r_clr_idx;

    // Configuration registers
    logic [PEN_W-1:0]    r_miss_pen;
    logic [PEN_W-1:0]    r_misp_pen;

    // Latched branch
    logic [ADDR_W-1:0]   r_addr;
    logic [SIZE_W-1:0]   r_size;
    logic                r_cond;
    logic [ADDR_W-1:0]   r_next;
    logic                r_pred;
    logic [STAMP_W-1:0]  r_now;

    // Set index reduction
    logic [ADDR_W-1:0]   r_sh;
    t_rem                r_rem;
    logic [MCNT_W-1:0]   r_mcnt;
    logic [IDX_W-1:0]    r_set;

    // Lookup decision
    logic                r_hit;
    logic [WAY_W-1:0]    r_way;

    // Output register
    logic                r_out_valid;
    logic                r_out_hit;
    logic [OWAY_W-1:0]   r_out_way;
    logic                r_out_taken;
    logic                r_out_mis;
    logic [STALL_W-1:0]  r_out_stall;

    // Set memory
    t_row                mem [SET_COUNT];
    t_row                r_row;

    logic                in_xfer;
    logic                out_free;
    logic [ADDR_W-1:0]   in_sh;
    logic [IDX_W-1:0]    in_set;
    t_rem                n_rem;
    logic                rd_en;
    logic [IDX_W-1:0]    rd_idx;
    logic                wr_en;
    logic [IDX_W-1:0]    wr_idx;
    t_row                wr_row;

    logic [WAY_COUNT-1:0] hit_vec;
    logic [WAY_COUNT-1:0] inv_vec;
    logic [WAY_COUNT-1:0] lru_vec;
    logic                 n_hit;
    logic [WAY_W-1:0]     n_way;
    logic [WAY_W-1:0]     hit_idx;
    logic [WAY_W-1:0]     inv_idx;
    logic [WAY_W-1:0]     lru_idx;

    t_way                 sel_way;
    t_row                 upd_row;
    logic [ADDR_W-1:0]    fill_tgt;
    logic                 use_cond;
    logic [ADDR_W-1:0]    use_tgt;
    logic                 n_taken;
    logic                 n_mis;
    logic [STALL_W-1:0]   n_stall;

    // Handshakes
    assign i_br.ready = (r_state == ST_IDLE);
    assign in_xfer    = i_br.valid && (r_state == ST_IDLE);
    assign out_free   = !r_out_valid || o_res.ready;

    assign o_res.valid          = r_out_valid;
    assign o_res.btb_hit        = r_out_hit;
    assign o_res.hit_way        = r_out_way;
    assign o_res.resolved_taken = r_out_taken;
    assign o_res.mispredicted   = r_out_mis;
    assign o_res.stall_cycles   = r_out_stall;

    // Configuration port: writes complete in the access phase, reads are direct
    assign pready = 1'b1;

    always_comb begin
        if (paddr[2] == REG_MISP_PEN) begin
            prdata = PDATA_W'(r_misp_pen);
        end else begin
            prdata = PDATA_W'(r_miss_pen);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_miss_pen <= '0;
            r_misp_pen <= '0;
        end else if (psel && penable && pwrite) begin
            if (paddr[2] == REG_MISP_PEN) begin
                r_misp_pen <= pwdata[PEN_W-1:0];
            end else begin
                r_miss_pen <= pwdata[PEN_W-1:0];
            end
        end
    end

    // Set index of an incoming branch when the set count is a power of two
    assign in_sh  = i_br.branch_addr >> 2;
    assign in_set = IDX_W'(in_sh & ADDR_W'(SET_COUNT - 1));
    assign n_rem  = mod_step(r_rem, r_sh[ADDR_W-1 -: MOD_BITS]);

    // Memory port control
    always_comb begin
        rd_en  = 1'b0;
        rd_idx = r_set;
        if (in_xfer && SET_POW2) begin
            rd_en  = 1'b1;
            rd_idx = in_set;
        end else if (r_state == ST_READ) begin
            rd_en  = 1'b1;
        end
    end

    always_comb begin
        wr_en  = 1'b0;
        wr_idx = r_set;
        wr_row = upd_row;
        if (r_state == ST_CLEAR) begin
            wr_en  = 1'b1;
            wr_idx = r_clr_idx;
            wr_row = '0;
        end else if (r_state == ST_WRITE && out_free) begin
            wr_en  = 1'b1;
        end
    end

    // Set memory with registered read data
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_idx] <= wr_row;
        end
        if (rd_en) begin
            r_row <= mem[rd_idx];
        end
    end

    // Hit, invalid and least recently used way vectors
    always_comb begin
        for (int i = 0; i < WAY_COUNT; i++) begin
            hit_vec[i] = r_row[i].valid && (r_row[i].tag == r_addr);
            inv_vec[i] = !r_row[i].valid;
            lru_vec[i] = 1'b1;
            for (int j = 0; j < WAY_COUNT; j++) begin
                if (j < i && !(r_row[i].stamp < r_row[j].stamp)) begin
                    lru_vec[i] = 1'b0;
                end
                if (j > i && !(r_row[i].stamp <= r_row[j].stamp)) begin
                    lru_vec[i] = 1'b0;
                end
            end
        end
    end

    // Lowest matching way of each vector
    always_comb begin
        hit_idx = '0;
        inv_idx = '0;
        lru_idx = '0;
        for (int i = WAY_COUNT - 1; i >= 0; i--) begin
            if (hit_vec[i]) begin
                hit_idx = WAY_W'(i);
            end
            if (inv_vec[i]) begin
                inv_idx = WAY_W'(i);
            end
            if (lru_vec[i]) begin
                lru_idx = WAY_W'(i);
            end
        end
        n_hit = |hit_vec;
        if (n_hit) begin
            n_way = hit_idx;
        end else if (|inv_vec) begin
            n_way = inv_idx;
        end else begin
            n_way = lru_idx;
        end
    end

    // Updated row, resolved direction and stall cycles
    always_comb begin
        sel_way  = r_row[r_way];
        fill_tgt = r_addr + ADDR_W'(r_size);
        upd_row  = r_row;
        upd_row[r_way].stamp = r_now;
        if (r_hit) begin
            use_cond = sel_way.cond;
            use_tgt  = sel_way.target;
        end else begin
            use_cond = r_cond;
            use_tgt  = fill_tgt;
            upd_row[r_way].valid  = 1'b1;
            upd_row[r_way].cond   = r_cond;
            upd_row[r_way].tag    = r_addr;
            upd_row[r_way].target = fill_tgt;
        end
        n_taken = use_cond && (r_next != use_tgt);
        n_mis   = (r_pred != n_taken);
        n_stall = (r_hit ? '0 : STALL_W'(r_miss_pen))
                + (n_mis ? STALL_W'(r_misp_pen) : '0);
    end

    // Control sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr_idx   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // The result register fills on write-back and empties on a transfer
            if (r_state == ST_WRITE && out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_CLEAR: begin
                    r_clr_idx <= r_clr_idx + 1'b1;
                    if (r_clr_idx == IDX_W'(SET_COUNT - 1)) begin
                        r_state <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (i_br.valid) begin
                        r_state <= SET_POW2 ? ST_LOOK : ST_MOD;
                    end
                end
                ST_MOD: begin
                    if (r_mcnt == MCNT_W'(MOD_STEPS - 1)) begin
                        r_state <= ST_READ;
                    end
                end
                ST_READ: begin
                    r_state <= ST_LOOK;
                end
                ST_LOOK: begin
                    r_state <= ST_WRITE;
                end
                ST_WRITE: begin
                    if (out_free) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_addr <= i_br.branch_addr;
            r_size <= i_br.instr_size;
            r_cond <= i_br.is_conditional;
            r_next <= i_br.next_addr;
            r_pred <= i_br.predicted_taken;
            r_now  <= i_br.cycle_now;
            r_sh   <= in_sh;
            r_rem  <= '0;
            r_mcnt <= '0;
            r_set  <= in_set;
        end
        if (r_state == ST_MOD) begin
            r_rem  <= n_rem;
            r_sh   <= r_sh << MOD_BITS;
            r_mcnt <= r_mcnt + 1'b1;
            r_set  <= IDX_W'(n_rem);
        end
        if (r_state == ST_LOOK) begin
            r_hit <= n_hit;
            r_way <= n_way;
        end
        if (r_state == ST_WRITE && out_free) begin
            r_out_hit   <= r_hit;
            r_out_way   <= OWAY_W'(r_way);
            r_out_taken <= n_taken;
            r_out_mis   <= n_mis;
            r_out_stall <= n_stall;
        end
    end

endmodule
